FILE: design/bott_pkg.sv
// Package for the box overlap tracking table: sizes, box type, opcodes, states.
// Also holds the overlap test. Used by bott_ram users and the top level.
// No dependencies.
package bott_pkg;

	localparam int SLOTS      = 32;
	localparam int SLOT_W     = $clog2(SLOTS);
	localparam int PTR_W      = $clog2(SLOTS + 1);
	localparam int CNT_W      = $clog2(SLOTS + 1);
	localparam int COORD_BITS = 16;
	localparam int ENTRY_W    = 5;
	localparam int OP_W       = 2;
	localparam int BOX_W      = 4 * COORD_BITS;
	localparam int IN_DATA_W  = ((ENTRY_W + BOX_W + 7) / 8) * 8;
	localparam int OUT_FLDS_W = ENTRY_W + 1 + CNT_W;
	localparam int OUT_DATA_W = ((OUT_FLDS_W + 7) / 8) * 8;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_ERASE  = 2'd1,
		OP_MOVE   = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SINGLE,
		ST_SCAN,
		ST_CLOSE
	} state_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] hi_y;
		logic signed [COORD_BITS-1:0] hi_x;
		logic signed [COORD_BITS-1:0] lo_y;
		logic signed [COORD_BITS-1:0] lo_x;
	} box_t;

	function automatic logic overlaps(input box_t b, input box_t q);
		overlaps = (b.lo_x < q.hi_x) && (b.hi_x >= q.lo_x) &&
			(b.lo_y < q.hi_y) && (b.hi_y >= q.lo_y);
	endfunction

endpackage

FILE: design/bott_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module bott_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/box_overlap_tracking_table.sv
// Box overlap tracking table, top level.
// Depends on bott_pkg and bott_ram.
//
// Holds up to 32 boxes in a RAM plus a query box and reports every change of
// overlap membership as an enter or leave item, followed by one closing item
// (tlast) carrying the member count. One input item is taken at a time. Insert
// and erase of an entry in range update that single slot, then put the closing
// item in the output register. Move and clear walk every slot through the box
// RAM read port, one slot a cycle while no enter or leave item is held back by
// the output, and then emit the closing item. The next item is accepted in the
// cycle after the closing item enters the output register.
module box_overlap_tracking_table (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// entry, min_x, min_y, max_x, max_y, zero fill
	input  logic [bott_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// operation
	input  logic [bott_pkg::OP_W-1:0]       s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// changed_entry, entered, member_count, zero fill
	output logic [bott_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// closing
	output logic [0:0]                      m_axis_tuser,
	output logic                            m_axis_tlast
);

	localparam int CB = bott_pkg::COORD_BITS;
	localparam int EW = bott_pkg::ENTRY_W;

	bott_pkg::state_t state_q, state_d;
	bott_pkg::op_t    op_q;
	logic [EW-1:0]    ent_q;
	bott_pkg::box_t   box_q, query_q, in_box, rd_box;
	logic [bott_pkg::BOX_W-1:0]  rdata;
	logic [bott_pkg::SLOTS-1:0]  valid_q, inside_q;
	logic [bott_pkg::CNT_W-1:0]  count_q;
	logic [bott_pkg::PTR_W-1:0]  ptr_q;
	logic                        vld_s1;
	logic [bott_pkg::SLOT_W-1:0] slot_s1;

	logic                        out_valid_q, out_entered_q, out_closing_q;
	logic [EW-1:0]               out_slot_q;
	logic [bott_pkg::CNT_W-1:0]  out_count_q;

	logic                        accept, in_range, out_free, ptr_done, stall;
	logic                        sg_rel, sg_now, sg_change, s1_now, s1_change;
	logic                        wr_en, rd_en, emit, ev_entered, ev_closing;
	logic [bott_pkg::SLOT_W-1:0] ev_slot, ent_idx, wr_idx;
	logic                        upd_en, upd_now, drop_en;
	logic [bott_pkg::SLOT_W-1:0] upd_slot;

	assign in_box.lo_x = s_axis_tdata[EW +: CB];
	assign in_box.lo_y = s_axis_tdata[EW + CB +: CB];
	assign in_box.hi_x = s_axis_tdata[EW + 2*CB +: CB];
	assign in_box.hi_y = s_axis_tdata[EW + 3*CB +: CB];

	assign s_axis_tready = (state_q == bott_pkg::ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign wr_idx        = s_axis_tdata[bott_pkg::SLOT_W-1:0];
	assign in_range      = 32'(s_axis_tdata[EW-1:0]) < bott_pkg::SLOTS;
	assign wr_en         = accept && in_range &&
		(bott_pkg::op_t'(s_axis_tuser) == bott_pkg::OP_INSERT);

	bott_ram #(
		.WIDTH(bott_pkg::BOX_W),
		.DEPTH(bott_pkg::SLOTS)
	) u_box_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_idx),
		.wdata(in_box),
		.re   (rd_en),
		.raddr(ptr_q[bott_pkg::SLOT_W-1:0]),
		.rdata(rdata)
	);

	assign rd_box  = bott_pkg::box_t'(rdata);
	assign ent_idx = ent_q[bott_pkg::SLOT_W-1:0];

	// single-slot update (insert / erase)
	assign sg_rel    = (op_q == bott_pkg::OP_INSERT) || valid_q[ent_idx];
	assign sg_now    = (op_q == bott_pkg::OP_INSERT) && bott_pkg::overlaps(box_q, query_q);
	assign sg_change = sg_rel && (sg_now != inside_q[ent_idx]);

	// scan stage one: RAM data for slot_s1
	assign s1_now    = (op_q == bott_pkg::OP_MOVE) && valid_q[slot_s1] &&
		bott_pkg::overlaps(rd_box, query_q);
	assign s1_change = s1_now != inside_q[slot_s1];
	assign stall     = vld_s1 && s1_change && !out_free;
	assign ptr_done  = ptr_q == bott_pkg::PTR_W'(bott_pkg::SLOTS);

	always_comb begin
		state_d    = state_q;
		rd_en      = 1'b0;
		emit       = 1'b0;
		ev_slot    = '0;
		ev_entered = 1'b0;
		ev_closing = 1'b0;
		upd_en     = 1'b0;
		upd_now    = 1'b0;
		upd_slot   = '0;
		drop_en    = 1'b0;
		unique case (state_q)
			bott_pkg::ST_IDLE: begin
				if (s_axis_tvalid) begin
					case (bott_pkg::op_t'(s_axis_tuser)) inside
						bott_pkg::OP_INSERT, bott_pkg::OP_ERASE:
							state_d = in_range ? bott_pkg::ST_SINGLE : bott_pkg::ST_CLOSE;
						default:
							state_d = bott_pkg::ST_SCAN;
					endcase
				end
			end
			bott_pkg::ST_SINGLE: begin
				upd_slot = ent_idx;
				upd_now  = sg_now;
				ev_slot  = ent_idx;
				if (!sg_change || out_free) begin
					emit       = sg_change;
					ev_entered = sg_now;
					upd_en     = sg_change;
					drop_en    = (op_q == bott_pkg::OP_ERASE);
					state_d    = bott_pkg::ST_CLOSE;
				end
			end
			bott_pkg::ST_SCAN: begin
				rd_en    = !ptr_done && !stall;
				upd_slot = slot_s1;
				upd_now  = s1_now;
				ev_slot  = slot_s1;
				if (vld_s1 && !stall) begin
					emit       = s1_change;
					ev_entered = s1_now;
					upd_en     = s1_change;
					drop_en    = (op_q == bott_pkg::OP_CLEAR);
				end
				if (ptr_done && !vld_s1) begin
					state_d = bott_pkg::ST_CLOSE;
				end
			end
			bott_pkg::ST_CLOSE: begin
				if (out_free) begin
					emit       = 1'b1;
					ev_closing = 1'b1;
					state_d    = bott_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bott_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bott_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q     <= bott_pkg::OP_INSERT;
			query_q  <= '0;
			valid_q  <= '0;
			inside_q <= '0;
			count_q  <= '0;
			ptr_q    <= '0;
			vld_s1   <= 1'b0;
		end else begin
			if (accept) begin
				op_q  <= bott_pkg::op_t'(s_axis_tuser);
				ptr_q <= '0;
				if (bott_pkg::op_t'(s_axis_tuser) == bott_pkg::OP_MOVE ||
						bott_pkg::op_t'(s_axis_tuser) == bott_pkg::OP_CLEAR) begin
					query_q <= in_box;
				end
			end
			if (wr_en) begin
				valid_q[wr_idx] <= 1'b1;
			end
			if (upd_en) begin
				inside_q[upd_slot] <= upd_now;
				count_q <= upd_now ? count_q + 1'b1 : count_q - 1'b1;
			end
			if (drop_en) begin
				valid_q[upd_slot] <= 1'b0;
			end
			if (state_q == bott_pkg::ST_SCAN && !stall) begin
				vld_s1 <= rd_en;
				if (rd_en) begin
					ptr_q <= ptr_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ent_q <= s_axis_tdata[EW-1:0];
			box_q <= in_box;
		end
		if (rd_en) begin
			slot_s1 <= ptr_q[bott_pkg::SLOT_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_slot_q    <= EW'(ev_slot);
			out_entered_q <= ev_entered;
			out_closing_q <= ev_closing;
			out_count_q   <= ev_closing ? count_q : '0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(bott_pkg::OUT_DATA_W - bott_pkg::OUT_FLDS_W){1'b0}},
		out_count_q, out_entered_q, out_slot_q};
	assign m_axis_tuser  = out_closing_q;
	assign m_axis_tlast  = out_closing_q;

endmodule
